// ===== rtl/hss_pkg.sv =====
// ----------------------------------------------------------------------------
// hss_pkg
// Shared constants for the hover setpoint sequencer: phase codes, register
// indexes, register reset values and datapath widths.
// ----------------------------------------------------------------------------
package hss_pkg;

  // Datapath widths
  localparam int POS_W   = 32;
  localparam int TIME_W  = 48;
  localparam int DUR_W   = 30;
  localparam int PHASE_W = 3;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = POS_W + DUR_W;
  localparam int DVD_W   = PROD_W + 1;
  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DELAY  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_GO     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HOVER  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RETURN = 3'd4;
  localparam logic [PHASE_W-1:0] PH_HOME   = 3'd5;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_HOVER_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_HOVER_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_HOVER_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_DELAY   = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRAVEL  = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOLD    = 3'd5;
  localparam logic [IDX_W-1:0] REG_RETURN  = 3'd6;

  // Register reset values
  localparam logic [POS_W-1:0] RST_HOVER_X = 32'h0000_0000;
  localparam logic [POS_W-1:0] RST_HOVER_Y = 32'h0000_0000;
  localparam logic [POS_W-1:0] RST_HOVER_Z = 32'hFFFF_C000; // -0.25 m
  localparam logic [DUR_W-1:0] RST_DELAY   = 30'd1000000;
  localparam logic [DUR_W-1:0] RST_TRAVEL  = 30'd3000000;
  localparam logic [DUR_W-1:0] RST_HOLD    = 30'd5000000;
  localparam logic [DUR_W-1:0] RST_RETURN  = 30'd3000000;

  // Shortest ramp time, microseconds
  localparam logic [DUR_W-1:0] MIN_RAMP_US = 30'd10000;

endpackage

// ===== rtl/hss_div.sv =====
// ----------------------------------------------------------------------------
// hss_div
// Restoring divider, one quotient bit per cycle. The dividend must be below
// divisor * 2^POS_W, so the quotient fits POS_W bits and only POS_W steps
// are needed.
// ----------------------------------------------------------------------------
module hss_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hss_pkg::DVD_W-1:0]     dividend,
  input  logic [hss_pkg::DUR_W-1:0]     divisor,
  output logic                          done,
  output logic [hss_pkg::POS_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(hss_pkg::POS_W);

  logic [hss_pkg::DUR_W-1:0] rem_r;
  logic [hss_pkg::POS_W-1:0] q_r;
  logic [hss_pkg::DUR_W-1:0] dsr_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [hss_pkg::DUR_W:0]   rem_sh;
  logic                      ge;
  logic [hss_pkg::DUR_W:0]   rem_sub;
  logic                      last_step;

  // Shift one dividend bit in, subtract where it fits
  assign rem_sh  = {rem_r, q_r[hss_pkg::POS_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  assign last_step = busy_r && !start && (cnt_r == CNT_W'(hss_pkg::POS_W - 1));

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[hss_pkg::DVD_W-2 -: hss_pkg::DUR_W];
      q_r   <= dividend[hss_pkg::POS_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[hss_pkg::DUR_W-1:0] : rem_sh[hss_pkg::DUR_W-1:0];
      q_r   <= {q_r[hss_pkg::POS_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/hover_setpoint_sequencer.sv =====
// ----------------------------------------------------------------------------
// hover_setpoint_sequencer
// Phase sequencer for a hover flight: wait for home, start delay, ramp out,
// hover hold, ramp back, hold home. Ramp ticks interpolate each axis through
// one shared multiplier and one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Steps: an accepted word passes the latch and evaluate states to the done
//   state; on a ramp tick each axis in turn first passes the multiply, divider
//   start and divider wait states, the 32-step divider shared over the axes.
// Throughput: one word at a time; the next input word is taken the cycle
//   after the result is loaded into the output register.
// Reset: synchronous, active low; clears the phase to wait-for-home, drops
//   the home latch and restores the register defaults.
// ----------------------------------------------------------------------------
module hover_setpoint_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hss_pkg::IDX_W-1:0]         cfg_index,
  input  logic [hss_pkg::POS_W-1:0]         cfg_data,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hss_pkg::TIME_W-1:0]        in_time_us,
  input  logic signed [hss_pkg::POS_W-1:0]  in_meas_x,
  input  logic signed [hss_pkg::POS_W-1:0]  in_meas_y,
  input  logic signed [hss_pkg::POS_W-1:0]  in_meas_z,
  input  logic                              in_meas_valid,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hss_pkg::POS_W-1:0]  out_ref_x,
  output logic signed [hss_pkg::POS_W-1:0]  out_ref_y,
  output logic signed [hss_pkg::POS_W-1:0]  out_ref_z,
  output logic [hss_pkg::PHASE_W-1:0]       out_phase
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LATCH  = 3'd1;
  localparam logic [2:0] ST_EVAL   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DSTART = 3'd4;
  localparam logic [2:0] ST_DWAIT  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  localparam int POS_W  = hss_pkg::POS_W;
  localparam int TIME_W = hss_pkg::TIME_W;
  localparam int DUR_W  = hss_pkg::DUR_W;

  // Configuration registers
  logic [POS_W-1:0]  hover_r [hss_pkg::NUM_AXES];
  logic [DUR_W-1:0]  delay_r;
  logic [DUR_W-1:0]  travel_r;
  logic [DUR_W-1:0]  hold_r;
  logic [DUR_W-1:0]  return_r;

  // Sequencer state
  logic [2:0]                  state_r, state_nxt;
  logic [hss_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [TIME_W-1:0]           pstart_r, pstart_nxt;
  logic                        homed_r, homed_nxt;
  logic [hss_pkg::AXIS_W-1:0]  axis_r, axis_nxt;
  logic                        out_valid_r;

  // Working registers
  logic [POS_W-1:0]          home_r [hss_pkg::NUM_AXES];
  logic [POS_W-1:0]          meas_r [hss_pkg::NUM_AXES];
  logic [POS_W-1:0]          ref_r  [hss_pkg::NUM_AXES];
  logic [TIME_W-1:0]         time_r;
  logic                      mvalid_r;
  logic [DUR_W-1:0]          elapsed_r;
  logic [DUR_W-1:0]          den_r;
  logic                      back_r;
  logic [hss_pkg::PROD_W-1:0] prod_r;
  logic                      neg_r;

  // Output registers
  logic [POS_W-1:0]            out_x_r, out_y_r, out_z_r;
  logic [hss_pkg::PHASE_W-1:0] out_phase_r;

  logic                      in_take;
  logic                      out_load;
  logic [TIME_W-1:0]         elapsed;
  logic [DUR_W-1:0]          tr;
  logic [DUR_W-1:0]          rt;
  logic                      dly_over, tr_over, hold_over, rt_over;
  logic [POS_W-1:0]          from_pos, to_pos;
  logic [POS_W:0]            diff;
  logic [POS_W-1:0]          mag;
  logic                      div_start;
  logic                      div_done;
  logic [POS_W-1:0]          div_q;
  logic [hss_pkg::DVD_W-1:0] dividend;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Time in phase, clamped at zero when time runs backwards
  assign elapsed = (time_r >= pstart_r) ? (time_r - pstart_r) : '0;

  // Floor the ramp times
  assign tr = (travel_r < hss_pkg::MIN_RAMP_US) ? hss_pkg::MIN_RAMP_US : travel_r;
  assign rt = (return_r < hss_pkg::MIN_RAMP_US) ? hss_pkg::MIN_RAMP_US : return_r;

  assign dly_over  = elapsed >= TIME_W'(delay_r);
  assign tr_over   = elapsed >= TIME_W'(tr);
  assign hold_over = elapsed >= TIME_W'(hold_r);
  assign rt_over   = elapsed >= TIME_W'(rt);

  // Ramp endpoints for the axis in work
  assign from_pos = back_r ? hover_r[axis_r] : home_r[axis_r];
  assign to_pos   = back_r ? home_r[axis_r]  : hover_r[axis_r];
  assign diff     = {to_pos[POS_W-1], to_pos} - {from_pos[POS_W-1], from_pos};
  assign mag      = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];

  // Round to nearest: add half the divisor before dividing
  assign dividend = {1'b0, prod_r} + hss_pkg::DVD_W'(den_r >> 1);

  hss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer next state
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    pstart_nxt = pstart_r;
    homed_nxt  = homed_r;
    axis_nxt   = axis_r;
    div_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_LATCH;
        end
      end
      ST_LATCH: begin
        if (!homed_r && mvalid_r) begin
          homed_nxt  = 1'b1;
          phase_nxt  = hss_pkg::PH_DELAY;
          pstart_nxt = time_r;
        end
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_DONE;
        axis_nxt  = '0;
        case (phase_r)
          hss_pkg::PH_DELAY: begin
            if (dly_over) begin
              phase_nxt  = hss_pkg::PH_GO;
              pstart_nxt = time_r;
            end
          end
          hss_pkg::PH_GO: begin
            if (tr_over) begin
              phase_nxt  = hss_pkg::PH_HOVER;
              pstart_nxt = time_r;
            end else begin
              state_nxt = ST_MUL;
            end
          end
          hss_pkg::PH_HOVER: begin
            if (hold_over) begin
              phase_nxt  = hss_pkg::PH_RETURN;
              pstart_nxt = time_r;
            end
          end
          hss_pkg::PH_RETURN: begin
            if (rt_over) begin
              phase_nxt  = hss_pkg::PH_HOME;
              pstart_nxt = time_r;
            end else begin
              state_nxt = ST_MUL;
            end
          end
          default: begin
          end
        endcase
      end
      ST_MUL: begin
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          if (axis_r == hss_pkg::AXIS_W'(hss_pkg::NUM_AXES - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= hss_pkg::PH_WAIT;
      pstart_r    <= '0;
      homed_r     <= 1'b0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      pstart_r <= pstart_nxt;
      homed_r  <= homed_nxt;
      axis_r   <= axis_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hover_r[0] <= hss_pkg::RST_HOVER_X;
      hover_r[1] <= hss_pkg::RST_HOVER_Y;
      hover_r[2] <= hss_pkg::RST_HOVER_Z;
      delay_r    <= hss_pkg::RST_DELAY;
      travel_r   <= hss_pkg::RST_TRAVEL;
      hold_r     <= hss_pkg::RST_HOLD;
      return_r   <= hss_pkg::RST_RETURN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hss_pkg::REG_HOVER_X: hover_r[0] <= cfg_data;
        hss_pkg::REG_HOVER_Y: hover_r[1] <= cfg_data;
        hss_pkg::REG_HOVER_Z: hover_r[2] <= cfg_data;
        hss_pkg::REG_DELAY:   delay_r    <= cfg_data[DUR_W-1:0];
        hss_pkg::REG_TRAVEL:  travel_r   <= cfg_data[DUR_W-1:0];
        hss_pkg::REG_HOLD:    hold_r     <= cfg_data[DUR_W-1:0];
        hss_pkg::REG_RETURN:  return_r   <= cfg_data[DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Home position, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r[0] <= '0;
      home_r[1] <= '0;
      home_r[2] <= '0;
    end else if (state_r == ST_LATCH && !homed_r && mvalid_r) begin
      home_r[0] <= meas_r[0];
      home_r[1] <= meas_r[1];
      home_r[2] <= meas_r[2];
    end
  end

  // Datapath: capture the word, pick the reference, run the ramp axes
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          time_r    <= in_time_us;
          meas_r[0] <= in_meas_x;
          meas_r[1] <= in_meas_y;
          meas_r[2] <= in_meas_z;
          mvalid_r  <= in_meas_valid;
        end
      end
      ST_EVAL: begin
        elapsed_r <= elapsed[DUR_W-1:0];
        den_r     <= (phase_r == hss_pkg::PH_GO) ? tr : rt;
        back_r    <= (phase_r == hss_pkg::PH_RETURN);
        case (phase_r)
          hss_pkg::PH_WAIT: begin
            ref_r <= meas_r;
          end
          hss_pkg::PH_GO, hss_pkg::PH_HOVER: begin
            ref_r <= hover_r;
          end
          default: begin
            ref_r <= home_r;
          end
        endcase
      end
      ST_MUL: begin
        prod_r <= hss_pkg::PROD_W'(mag) * hss_pkg::PROD_W'(elapsed_r);
        neg_r  <= diff[POS_W];
      end
      ST_DWAIT: begin
        if (div_done) begin
          ref_r[axis_r] <= neg_r ? (from_pos - div_q) : (from_pos + div_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r     <= ref_r[0];
      out_y_r     <= ref_r[1];
      out_z_r     <= ref_r[2];
      out_phase_r <= phase_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ref_x = out_x_r;
  assign out_ref_y = out_y_r;
  assign out_ref_z = out_z_r;
  assign out_phase = out_phase_r;

endmodule

// ===== rtl/hss_chk.sv =====
// ----------------------------------------------------------------------------
// hss_chk
// Port-level checks for the hover setpoint sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module hss_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [hss_pkg::POS_W-1:0]  out_ref_x,
  input logic signed [hss_pkg::POS_W-1:0]  out_ref_y,
  input logic signed [hss_pkg::POS_W-1:0]  out_ref_z,
  input logic [hss_pkg::PHASE_W-1:0]       out_phase
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ref_x) &&
      $stable(out_ref_y) && $stable(out_ref_z) && $stable(out_phase))
    else $error("stalled result word changed");

  // Phase code stays in the used range
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase <= hss_pkg::PH_HOME)
    else $error("result phase out of range");

  // Busy after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  // A new result only follows work on an input word
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an input word in work");

endmodule

bind hover_setpoint_sequencer hss_chk u_hss_chk (.*);
